// ===== design/kvnt_pkg.sv =====
`default_nettype none

package kvnt_pkg;

	localparam int FS_W      = 12;
	localparam int VEL_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [VEL_W-1:0]     VEL_MAX   = '1;
	localparam logic [FS_W-1:0]      FS_RESET  = 12'd4095;
	localparam logic [VEL_W-1:0]     THR_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} kvnt_cmd_t;

	typedef struct packed {
		logic sat;
	} kvnt_sts_t;

endpackage

`default_nettype wire

// ===== design/kvnt_ctrl.sv =====
`default_nettype none

module kvnt_ctrl
	import kvnt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire kvnt_sts_t sts,
	output kvnt_cmd_t      cmd
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_DIV,
		C_COMMIT
	} ctrl_state_t;

	localparam int CNT_W = $clog2(VEL_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VEL_W - 1);

	ctrl_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             commit_ok;

	assign in_ready   = (state_q == C_IDLE);
	assign out_valid  = out_valid_q;
	assign commit_ok  = (state_q == C_COMMIT) && (!out_valid_q || out_ready);

	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == C_DIV) && !sts.sat;
	assign cmd.commit = commit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= C_DIV;
					end
				end
				C_DIV: begin
					if (sts.sat || cnt_q == CNT_LAST) begin
						state_q <= C_COMMIT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				C_COMMIT: begin
					if (commit_ok) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase

			// hold result until transfer, refill on commit
			if (commit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/kvnt_dp.sv =====
`default_nettype none

module kvnt_dp
	import kvnt_pkg::*;
#(
	parameter int ADC_BITS = 12
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kvnt_cmd_t            cmd,
	output kvnt_sts_t                 sts,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FS_W-1:0]      cfg_data,
	input  wire logic [ADC_BITS-1:0]  adc_sample,
	input  wire logic                 damper_level,
	output logic                      event_valid,
	output logic                      note_on,
	output logic [VEL_W-1:0]          velocity
);

	typedef enum logic [1:0] {
		N_IDLE,
		N_ON,
		N_REPRESS,
		N_OFF
	} note_state_t;

	localparam int NW = ADC_BITS + VEL_W;
	localparam int RW = (NW > FS_W + VEL_W) ? NW : FS_W + VEL_W;
	localparam int DW = FS_W + VEL_W - 1;

	logic [FS_W-1:0]  fs_q;
	logic [VEL_W-1:0] thr_q;

	logic [RW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [VEL_W-1:0] quo_q;
	logic             sat_q;
	logic             damp_q;

	note_state_t      nst_q;
	logic             ev_q;
	logic             status_q;
	logic [VEL_W-1:0] held_q;
	logic [VEL_W-1:0] pend_q;

	logic [RW-1:0]    samp_x;
	logic [RW-1:0]    num;
	logic [FS_W-1:0]  fs_eff;
	logic [RW-1:0]    lim;
	logic [RW-1:0]    div_x;
	logic             fits;
	logic [VEL_W-1:0] vel;
	logic             above;
	logic             below;
	logic             damper_on;
	logic             pend_we;

	assign cfg_ready = 1'b1;

	// sample * 127 as a shift and subtract
	assign samp_x = RW'(adc_sample);
	assign num    = (samp_x << VEL_W) - samp_x;
	assign fs_eff = (fs_q == '0) ? FS_W'(1) : fs_q;
	assign lim    = RW'(fs_eff) << VEL_W;
	assign div_x  = RW'(div_q);
	assign fits   = (rem_q >= div_x);

	assign sts.sat   = sat_q;
	assign vel       = sat_q ? VEL_MAX : quo_q;
	assign above     = (vel > thr_q);
	assign below     = (vel < thr_q);
	assign damper_on = !damp_q;
	assign pend_we   = cmd.commit && (nst_q == N_ON) && !(below && damper_on)
	                   && above && !damper_on;

	assign event_valid = ev_q;
	assign note_on     = status_q;
	assign velocity    = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q  <= FS_RESET;
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FULL_SCALE: fs_q  <= cfg_data;
				REG_THRESHOLD:  thr_q <= cfg_data[VEL_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= num;
			div_q  <= DW'(fs_eff) << (VEL_W - 1);
			quo_q  <= '0;
			sat_q  <= (num >= lim);
			damp_q <= damper_level;
		end else if (cmd.step) begin
			if (fits) begin
				rem_q <= rem_q - div_x;
			end
			quo_q <= {quo_q[VEL_W-2:0], fits};
			div_q <= div_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_q <= vel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nst_q    <= N_IDLE;
			ev_q     <= 1'b0;
			status_q <= 1'b0;
			held_q   <= '0;
		end else if (cmd.commit) begin
			case (nst_q)
				N_IDLE: begin
					if (above && !damper_on) begin
						held_q   <= vel;
						status_q <= 1'b1;
						ev_q     <= 1'b1;
						nst_q    <= N_ON;
					end else begin
						ev_q <= 1'b0;
					end
				end
				N_ON: begin
					if (below && damper_on) begin
						held_q   <= '0;
						status_q <= 1'b0;
						ev_q     <= 1'b1;
						nst_q    <= N_OFF;
					end else if (above && !damper_on) begin
						held_q   <= '0;
						status_q <= 1'b0;
						ev_q     <= 1'b1;
						nst_q    <= N_REPRESS;
					end else begin
						ev_q <= 1'b0;
					end
				end
				N_REPRESS: begin
					held_q   <= pend_q;
					status_q <= 1'b1;
					ev_q     <= 1'b1;
					nst_q    <= N_ON;
				end
				N_OFF: begin
					ev_q  <= 1'b0;
					nst_q <= N_IDLE;
				end
				default: begin
					ev_q  <= 1'b0;
					nst_q <= N_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/key_velocity_note_trigger.sv =====
// Key velocity note trigger.
// Input channel (in_valid/in_ready) carries one tick: adc_sample and the
// active-low damper_level. Each accepted tick yields exactly one result on
// the output channel (out_valid/out_ready): event_valid, note_on, velocity.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// full scale (index 0) and trigger threshold (index 1); cfg_ready is always
// high. Write it only while no tick is in flight.
// The sample is scaled by a restoring divider that produces one velocity
// bit per cycle. A tick passes from accept through 7 divider steps to the
// commit that loads the output register; a sample that saturates at
// velocity 127 skips the divider steps.
// The divider handles one tick at a time; a new tick is accepted only
// after the previous one has committed.
// A new tick is accepted while the previous result waits in the output
// register; if the receiver stalls, the next result waits in commit until the
// output register frees up, and input stalls behind it.
// Reset: note state idle, note off, velocity 0, full scale 4095, threshold 64.
`default_nettype none

module key_velocity_note_trigger
	import kvnt_pkg::*;
#(
	parameter int ADC_BITS = 12
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FS_W-1:0]      cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ADC_BITS-1:0]  adc_sample,
	input  wire logic                 damper_level,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      event_valid,
	output logic                      note_on,
	output logic [VEL_W-1:0]          velocity
);

	kvnt_cmd_t cmd;
	kvnt_sts_t sts;

	kvnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kvnt_dp #(
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.adc_sample   (adc_sample),
		.damper_level (damper_level),
		.event_valid  (event_valid),
		.note_on      (note_on),
		.velocity     (velocity)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second tick accepted while busy");

	a_off_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		!note_on |-> (velocity == '0))
		else $error("nonzero velocity with note off");

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result committed without returning to idle");

endmodule

`default_nettype wire

// ===== tb/key_velocity_note_checker.sv =====
`timescale 1ns / 100ps

module key_velocity_note_checker
	import kvnt_pkg::*;
#(
	parameter int ADC_BITS = 12
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FS_W-1:0]      cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [ADC_BITS-1:0]  adc_sample,
	input  wire logic                 damper_level,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 event_valid,
	input  wire logic                 note_on,
	input  wire logic [VEL_W-1:0]     velocity,
	output int                        mismatches,
	output int                        outstanding
);

	typedef enum logic [1:0] {
		KEY_IDLE,
		KEY_HELD,
		KEY_REPRESS,
		KEY_RELEASED
	} key_state_t;

	typedef struct packed {
		logic             flag;
		logic             sounding;
		logic [VEL_W-1:0] vel;
	} note_msg_t;

	logic [FS_W-1:0]  full_scale;
	logic [VEL_W-1:0] threshold;
	key_state_t       key_state;
	logic             sounding;
	logic [VEL_W-1:0] held_vel;
	logic [VEL_W-1:0] pending_vel;
	logic             status;
	logic             flag;
	note_msg_t        note_queue[$];
	note_msg_t        want_msg;
	int               err_total = 0;

	function automatic logic [VEL_W-1:0] scaled_velocity(input logic [ADC_BITS-1:0] raw);
		int unsigned divisor;
		int unsigned quotient;
		divisor = (full_scale == '0) ? 1 : 32'(full_scale);
		quotient = 32'(raw);
		quotient = quotient * 32'(VEL_MAX) / divisor;
		return (quotient > 32'(VEL_MAX)) ? VEL_MAX : quotient[VEL_W-1:0];
	endfunction

	function automatic note_msg_t advance_key(input logic [ADC_BITS-1:0] raw, input logic damper);
		logic [VEL_W-1:0] vel;
		logic             damper_on;
		logic             above;
		logic             below;
		vel = scaled_velocity(raw);
		damper_on = !damper;
		above = vel > threshold;
		below = vel < threshold;
		case (key_state)
			KEY_IDLE: begin
				if (!sounding && above && !damper_on) begin
					held_vel = vel;
					status = 1'b1;
					sounding = 1'b1;
					flag = 1'b1;
					key_state = KEY_HELD;
				end else begin
					flag = 1'b0;
				end
			end
			KEY_HELD: begin
				if (sounding && below && damper_on) begin
					held_vel = '0;
					status = 1'b0;
					sounding = 1'b0;
					flag = 1'b1;
					key_state = KEY_RELEASED;
				end else if (sounding && above && !damper_on) begin
					pending_vel = vel;
					held_vel = '0;
					status = 1'b0;
					sounding = 1'b0;
					flag = 1'b1;
					key_state = KEY_REPRESS;
				end else begin
					flag = 1'b0;
				end
			end
			KEY_REPRESS: begin
				held_vel = pending_vel;
				status = 1'b1;
				sounding = 1'b1;
				flag = 1'b1;
				key_state = KEY_HELD;
			end
			default: begin
				flag = 1'b0;
				key_state = KEY_IDLE;
			end
		endcase
		return '{flag: flag, sounding: status, vel: held_vel};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale = FS_RESET;
			threshold = THR_RESET;
			key_state = KEY_IDLE;
			sounding = 1'b0;
			held_vel = '0;
			pending_vel = '0;
			status = 1'b0;
			flag = 1'b0;
			note_queue.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FULL_SCALE: full_scale = cfg_data;
					REG_THRESHOLD:  threshold = cfg_data[VEL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (note_queue.size() == 0) begin
					$error("unexpected result: event_valid %0d note_on %0d velocity %0d",
						event_valid, note_on, velocity);
					err_total++;
				end else begin
					want_msg = note_queue.pop_front();
					if (event_valid !== want_msg.flag) begin
						$error("event_valid: expected %0d, got %0d", want_msg.flag, event_valid);
						err_total++;
					end
					if (note_on !== want_msg.sounding) begin
						$error("note_on: expected %0d, got %0d", want_msg.sounding, note_on);
						err_total++;
					end
					if (velocity !== want_msg.vel) begin
						$error("velocity: expected %0d, got %0d", want_msg.vel, velocity);
						err_total++;
					end
				end
			end
			if (in_valid && in_ready)
				note_queue.push_back(advance_key(adc_sample, damper_level));
			outstanding <= note_queue.size();
			mismatches <= err_total;
		end
	end

endmodule

// ===== tb/tb_key_velocity_note_trigger.sv =====
`timescale 1ns / 100ps

module tb_key_velocity_note_trigger
	import kvnt_pkg::*;
();

	localparam int          ADC_BITS   = 12;
	localparam int unsigned SAMPLE_MAX = (1 << ADC_BITS) - 1;
	localparam int unsigned VEL_TOP    = 32'(VEL_MAX);

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [FS_W-1:0]      cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [ADC_BITS-1:0]  adc_sample   = '0;
	logic                 damper_level = 1'b1;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic                 event_valid;
	logic                 note_on;
	logic [VEL_W-1:0]     velocity;

	int          note_errors;
	int          notes_pending;
	int unsigned cur_fs  = 32'(FS_RESET);
	int unsigned cur_thr = 32'(THR_RESET);
	logic        burst   = 1'b0;

	key_velocity_note_trigger #(.ADC_BITS(ADC_BITS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.adc_sample   (adc_sample),
		.damper_level (damper_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_valid  (event_valid),
		.note_on      (note_on),
		.velocity     (velocity)
	);

	key_velocity_note_checker #(.ADC_BITS(ADC_BITS)) note_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.adc_sample   (adc_sample),
		.damper_level (damper_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_valid  (event_valid),
		.note_on      (note_on),
		.velocity     (velocity),
		.mismatches   (note_errors),
		.outstanding  (notes_pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#6ms;
		$display("key_velocity_note_trigger verification failed");
		$finish;
	end

	function automatic int unsigned send_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int unsigned ready_run();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 95)
			return $urandom_range(10, 40);
		return $urandom_range(100, 300);
	endfunction

	function automatic int unsigned stall_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// pick a sample that scales to about the given velocity
	function automatic logic [ADC_BITS-1:0] sample_for(input int unsigned vel);
		int unsigned fse;
		int unsigned s;
		fse = (cur_fs == 0) ? 1 : cur_fs;
		s = (vel * fse + VEL_TOP - 1) / VEL_TOP;
		case ($urandom_range(0, 3))
			0: if (s > 0) s--;
			1: s++;
			default: ;
		endcase
		if (s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		return s[ADC_BITS-1:0];
	endfunction

	initial begin
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat (ready_run()) @(posedge clk);
			out_ready <= 1'b0;
			repeat (stall_len()) @(posedge clk);
		end
	end

	task automatic send_tick(input logic [ADC_BITS-1:0] raw, input logic damper);
		int unsigned gap;
		gap = burst ? 0 : send_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= raw;
		damper_level <= damper;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold input until every result has drained
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (notes_pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FS_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FULL_SCALE: cur_fs = 32'(data);
			REG_THRESHOLD:  cur_thr = 32'(data[VEL_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [FS_W-1:0] fs, input logic [VEL_W-1:0] thr);
		logic [FS_W-1:0] thr_word;
		wait_quiet();
		write_reg(REG_FULL_SCALE, fs);
		thr_word = FS_W'($urandom);
		thr_word[VEL_W-1:0] = thr;
		write_reg(REG_THRESHOLD, thr_word);
	endtask

	// mostly press/release sequences around the threshold, some noise
	task automatic random_ticks(input int count);
		int unsigned         pick;
		int unsigned         target;
		logic [ADC_BITS-1:0] raw;
		logic                damper;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 199) == 0)
				wait_quiet();
			pick = $urandom_range(0, 99);
			target = cur_thr;
			damper = 1'($urandom_range(0, 1));
			if (pick < 40) begin
				target = (cur_thr >= VEL_TOP) ? VEL_TOP : $urandom_range(cur_thr + 1, VEL_TOP);
				damper = 1'b1;
			end else if (pick < 75) begin
				target = (cur_thr == 0) ? 0 : $urandom_range(0, cur_thr - 1);
				damper = 1'b0;
			end
			if (pick < 85)
				raw = sample_for(target);
			else
				raw = ADC_BITS'($urandom);
			if (pick < 75 && $urandom_range(0, 6) == 0)
				damper = !damper;
			send_tick(raw, damper);
		end
		burst = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_config(12'd127, 7'd64);
		send_tick('0, 1'b1);
		send_tick(ADC_BITS'(64), 1'b1);
		send_tick(ADC_BITS'(100), 1'b0);
		send_tick(ADC_BITS'(100), 1'b1);
		send_tick(ADC_BITS'(64), 1'b0);
		send_tick(ADC_BITS'(127), 1'b1);
		send_tick('0, 1'b1);
		send_tick(ADC_BITS'(10), 1'b1);
		send_tick(ADC_BITS'(10), 1'b0);
		send_tick(ADC_BITS'(SAMPLE_MAX), 1'b1);
		send_tick(ADC_BITS'(SAMPLE_MAX), 1'b1);
		send_tick('0, 1'b0);
		send_tick('0, 1'b0);

		set_config('0, '0);
		send_tick(ADC_BITS'(1), 1'b1);
		send_tick('0, 1'b1);
		send_tick(ADC_BITS'(SAMPLE_MAX), 1'b1);
		send_tick('0, 1'b0);

		set_config(12'd4095, 7'd127);
		send_tick(ADC_BITS'(SAMPLE_MAX), 1'b0);
		send_tick('0, 1'b0);
		send_tick('0, 1'b1);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: set_config(FS_RESET, THR_RESET);
				1: set_config(12'd127, 7'd64);
				2: set_config('0, '0);
				3: set_config(12'd1, 7'd127);
				4: set_config(12'd4095, 7'd127);
				5: set_config(12'd4095, '0);
				6: set_config(FS_W'($urandom_range(1, 200)), VEL_W'($urandom_range(0, 127)));
				default: set_config(FS_W'($urandom_range(1, 4095)),
					VEL_W'($urandom_range(0, 127)));
			endcase
			random_ticks(150);
		end

		wait_quiet();
		repeat (20) @(posedge clk);
		if (note_errors == 0)
			$display("key_velocity_note_trigger verification clean");
		else
			$display("key_velocity_note_trigger verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/kvnt_pkg.sv
design/kvnt_ctrl.sv
design/kvnt_dp.sv
design/key_velocity_note_trigger.sv
tb/key_velocity_note_checker.sv
tb/tb_key_velocity_note_trigger.sv
